// ===== sv/tss_pkg.sv =====
`default_nettype none
package tss_pkg;

    // Register indexes on the configuration port
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] CFG_OWN_ID = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SLOT_COUNT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CYCLE_COUNT = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEEP_SUPER = 2'd3;

    // Request types
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_PKT = 1'b1;

    // Radio commands
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_TX = 2'd1;
    localparam logic [1:0] CMD_RX = 2'd2;
    localparam logic [1:0] CMD_SLEEP = 2'd3;

    // Tracked radio mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX = 2'd1,
        MODE_TX = 2'd2
    } radio_mode_t;

    // Input word
    typedef struct packed {
        logic        req_type;
        logic        pkt_ok;
        logic [15:0] pkt_time_src;
        logic [7:0]  pkt_cycle;
        logic [15:0] pkt_sender;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [1:0]  radio_cmd;
        logic [15:0] slot_now;
        logic [7:0]  cycle_now;
        logic [15:0] time_src_id;
        logic        resynced;
    } out_word_t;

    // Configuration registers
    typedef struct packed {
        logic [15:0] own_id;
        logic [12:0] slot_count;
        logic [8:0]  cycle_count;
        logic [7:0]  keep_supercycles;
    } cfg_t;

    // Timekeeping state
    typedef struct packed {
        logic [15:0] slot;
        logic [7:0]  cycle;
        logic [15:0] src_id;
        logic [7:0]  src_age;
        radio_mode_t mode;
    } sync_state_t;

endpackage
`default_nettype wire

// ===== sv/tss_core.sv =====
`default_nettype none
// Next-state and result logic for one word: for a tick or resync, take the base
// time (stored or from the packet), advance one slot, then pick the radio command.
module tss_core
    import tss_pkg::*;
(
    input  var in_word_t    item,
    input  var cfg_t        cfg,
    input  var sync_state_t cur,
    output sync_state_t     nxt,
    output out_word_t       res
);

    logic        resync;
    logic        do_slot;
    logic [16:0] base_slot;
    logic [7:0]  base_cycle;
    logic [15:0] base_src;
    logic [7:0]  base_age;
    radio_mode_t base_mode;
    logic [16:0] slot_sum;
    logic [8:0]  cyc_sum;
    logic [8:0]  ccount;
    logic        slot_wrap;
    logic        cyc_wrap;
    logic [15:0] adv_slot;
    logic [7:0]  adv_cycle;
    logic [15:0] adv_src;
    logic [7:0]  adv_age;
    radio_mode_t adv_mode;
    logic [1:0]  adv_cmd;

    // Resync decision for a good packet from a lower-ID source
    assign resync = (item.req_type == REQ_PKT) && item.pkt_ok
                    && (item.pkt_time_src < cur.src_id);
    assign do_slot = (item.req_type == REQ_TICK) || resync;

    // Base time for the slot advance
    always_comb begin
        if (item.req_type == REQ_PKT) begin
            base_slot = {1'b0, item.pkt_sender};
            base_cycle = item.pkt_cycle;
            base_src = item.pkt_time_src;
            base_age = 8'd0;
            base_mode = MODE_IDLE;
        end else begin
            base_slot = {1'b0, cur.slot};
            base_cycle = cur.cycle;
            base_src = cur.src_id;
            base_age = cur.src_age;
            base_mode = cur.mode;
        end
    end

    // Slot, cycle and supercycle wrap
    assign slot_sum = base_slot + 17'd1;
    assign cyc_sum = {1'b0, base_cycle} + 9'd1;
    assign ccount = (cfg.cycle_count > 9'd256) ? 9'd256 : cfg.cycle_count;
    assign slot_wrap = (slot_sum >= {4'd0, cfg.slot_count});
    assign cyc_wrap = (cyc_sum >= ccount) || (cyc_sum > 9'd255);

    always_comb begin
        adv_slot = slot_sum[15:0];
        adv_cycle = base_cycle;
        adv_src = base_src;
        adv_age = base_age;
        if (slot_wrap) begin
            adv_slot = 16'd0;
            adv_cycle = cyc_wrap ? 8'd0 : cyc_sum[7:0];
            if (cyc_wrap) begin
                if (base_age >= cfg.keep_supercycles) begin
                    adv_src = cfg.own_id;
                end else begin
                    adv_age = base_age + 8'd1;
                end
            end
        end
    end

    // Radio command for the new slot
    always_comb begin
        adv_mode = base_mode;
        adv_cmd = CMD_NONE;
        if (adv_slot == cfg.own_id) begin
            adv_mode = MODE_TX;
            adv_cmd = CMD_TX;
        end else if (adv_cycle == 8'd0) begin
            if (base_mode != MODE_RX) begin
                adv_mode = MODE_RX;
                adv_cmd = CMD_RX;
            end
        end else if (base_mode != MODE_IDLE) begin
            adv_mode = MODE_IDLE;
            adv_cmd = CMD_SLEEP;
        end
    end

    // Packet that does not resync only drops the radio to idle
    always_comb begin
        if (do_slot) begin
            nxt.slot = adv_slot;
            nxt.cycle = adv_cycle;
            nxt.src_id = adv_src;
            nxt.src_age = adv_age;
            nxt.mode = adv_mode;
            res.radio_cmd = adv_cmd;
        end else begin
            nxt = cur;
            nxt.mode = MODE_IDLE;
            res.radio_cmd = CMD_NONE;
        end
        res.slot_now = nxt.slot;
        res.cycle_now = nxt.cycle;
        res.time_src_id = nxt.src_id;
        res.resynced = resync;
    end

endmodule
`default_nettype wire

// ===== sv/tdma_slot_sync.sv =====
`default_nettype none
// TDMA slot timekeeper.
// Input channel s_valid/s_ready/s_data carries slot ticks and packet-done
// events; each accepted word gives exactly one result word on
// m_valid/m_ready/m_data (radio command, slot, cycle, time source, resync).
// An accepted word goes through the input register, then the state update and
// result register. Throughput: one word per cycle while the receiver does not
// stall; the state update in tss_core is combinational and the only loop, so
// consecutive words never wait on each other.
// When the receiver stalls, the result register holds, the input register
// fills, and s_ready drops until m_ready returns; no word is lost.
// Configuration: cfg_we/cfg_idx/cfg_wdata write one register per cycle; the user
// must write only while no word is in flight (the block does not enforce this).
// Writing own_id also reloads the time source. Reset (aresetn low, synchronous)
// empties both registers, clears slot, cycle and age, sets the radio mode idle and
// loads the register defaults (own_id 0, slot count 64, cycle count 4, keep_supercycles 4).
module tdma_slot_sync
    import tss_pkg::*;
(
    input  var logic                aclk,
    input  var logic                aresetn,
    input  var logic                s_valid,
    output logic                    s_ready,
    input  var in_word_t            s_data,
    output logic                    m_valid,
    input  var logic                m_ready,
    output out_word_t               m_data,
    input  var logic                cfg_we,
    input  var logic [CfgIdxW-1:0]  cfg_idx,
    input  var logic [CfgDataW-1:0] cfg_wdata
);

    cfg_t        cfg_reg;
    sync_state_t state_reg;
    sync_state_t state_next;
    logic        in_valid_reg;
    in_word_t    in_data_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;
    out_word_t   core_res;
    logic        advance;

    // Stage handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    tss_core u_core (
        .item (in_data_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (core_res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= core_res;
        end
    end

    // Configuration registers and timekeeping state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_id <= 16'd0;
            cfg_reg.slot_count <= 13'd64;
            cfg_reg.cycle_count <= 9'd4;
            cfg_reg.keep_supercycles <= 8'd4;
            state_reg.slot <= 16'd0;
            state_reg.cycle <= 8'd0;
            state_reg.src_id <= 16'd0;
            state_reg.src_age <= 8'd0;
            state_reg.mode <= MODE_IDLE;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_OWN_ID: begin
                        cfg_reg.own_id <= cfg_wdata;
                        state_reg.src_id <= cfg_wdata;
                    end
                    CFG_SLOT_COUNT: cfg_reg.slot_count <= cfg_wdata[12:0];
                    CFG_CYCLE_COUNT: cfg_reg.cycle_count <= cfg_wdata[8:0];
                    CFG_KEEP_SUPER: cfg_reg.keep_supercycles <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // A word in the input stage always moves on once the result side frees
    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    // A shown result matches the stored time base
    a_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.slot_now == state_reg.slot)
                          && (out_data_reg.cycle_now == state_reg.cycle))
        else $error("result slot/cycle differ from stored state");

    // Transmit only in own slot
    a_tx_own_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (core_res.radio_cmd == CMD_TX)
        |-> (core_res.slot_now == cfg_reg.own_id))
        else $error("transmit outside own slot");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !in_valid_reg)
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import tss_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 120;

    // Timekeeper scoreboard: tracks slot, cycle and time source per accepted word
    class slot_sync_scoreboard;
        logic [15:0] own_id;
        logic [12:0] slot_count;
        logic [8:0]  cycle_count;
        logic [7:0]  keep_super;

        logic [16:0] slot;
        logic [7:0]  cycle;
        logic [15:0] src_id;
        logic [7:0]  src_age;
        radio_mode_t mode;

        out_word_t due_reports[$];
        int        mismatches;

        function new();
            own_id = '0;
            slot_count = 13'd64;
            cycle_count = 9'd4;
            keep_super = 8'd4;
            slot = '0;
            cycle = '0;
            src_id = '0;
            src_age = '0;
            mode = MODE_IDLE;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
            case (idx)
                CFG_OWN_ID: begin
                    own_id = value;
                    src_id = value;
                end
                CFG_SLOT_COUNT: slot_count = value[12:0];
                CFG_CYCLE_COUNT: cycle_count = value[8:0];
                CFG_KEEP_SUPER: keep_super = value[7:0];
                default: ;
            endcase
        endfunction

        // Step slot, wrap into cycle and supercycle, age or drop the source
        function void step_slot();
            logic [8:0] cyc_lim;
            logic [8:0] next_cycle;
            cyc_lim = (cycle_count > 9'd256) ? 9'd256 : cycle_count;
            slot = slot + 17'd1;
            if (slot >= {4'd0, slot_count}) begin
                slot = '0;
                next_cycle = {1'b0, cycle} + 9'd1;
                if (next_cycle >= cyc_lim || next_cycle > 9'd255) begin
                    cycle = '0;
                    if (src_age >= keep_super)
                        src_id = own_id;
                    else
                        src_age = src_age + 8'd1;
                end else begin
                    cycle = next_cycle[7:0];
                end
            end
        endfunction

        // New slot: advance, then pick the radio command from the tracked mode
        function logic [1:0] open_slot();
            step_slot();
            if (slot == {1'b0, own_id}) begin
                mode = MODE_TX;
                return CMD_TX;
            end
            if (cycle == 8'd0) begin
                if (mode != MODE_RX) begin
                    mode = MODE_RX;
                    return CMD_RX;
                end
            end else if (mode != MODE_IDLE) begin
                mode = MODE_IDLE;
                return CMD_SLEEP;
            end
            return CMD_NONE;
        endfunction

        function void note_input(in_word_t w);
            out_word_t rep;
            rep = '0;
            if (w.req_type == REQ_TICK) begin
                rep.radio_cmd = open_slot();
            end else begin
                mode = MODE_IDLE;
                rep.radio_cmd = CMD_NONE;
                // lower-ID source takes over the time base
                if (w.pkt_ok && w.pkt_time_src < src_id) begin
                    cycle = w.pkt_cycle;
                    slot = {1'b0, w.pkt_sender};
                    src_id = w.pkt_time_src;
                    src_age = '0;
                    rep.resynced = 1'b1;
                    rep.radio_cmd = open_slot();
                end
            end
            rep.slot_now = slot[15:0];
            rep.cycle_now = cycle;
            rep.time_src_id = src_id;
            due_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (due_reports.size() == 0) begin
                $error("result word with nothing outstanding: 0x%0h", got);
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("radio_cmd", 16'(want.radio_cmd), 16'(got.radio_cmd));
            compare_field("slot_now", want.slot_now, got.slot_now);
            compare_field("cycle_now", 16'(want.cycle_now), 16'(got.cycle_now));
            compare_field("time_src_id", want.time_src_id, got.time_src_id);
            compare_field("resynced", 16'(want.resynced), 16'(got.resynced));
        endfunction

        function int pending();
            return due_reports.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_word_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_word_t           m_data;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    slot_sync_scoreboard sb = new();
    bit hold_off_req = 1'b0;
    int idle_cycles = 0;

    tdma_slot_sync u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Monitor both channels; input noted before the result check
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    // Result sink: random ready, plus one long hold-off on request
    initial begin : result_sink
        int run;
        bit hold_done;
        run = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
                run = $urandom_range(5, 20);
            end else if (run > 0) begin
                run--;
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
                run = $urandom_range(0, 40);
            end
        end
    end

    // Offer one word after an optional gap; returns right after acceptance
    task automatic offer_event(in_word_t w, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait for all outstanding results, then a few quiet cycles
    task automatic settle();
        repeat (3) @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(logic [15:0] own, logic [15:0] slots,
                                  logic [15:0] cycles, logic [15:0] keep);
        logic [CfgIdxW-1:0] idx_list [4];
        logic [CfgDataW-1:0] val_list [4];
        idx_list = '{CFG_OWN_ID, CFG_SLOT_COUNT, CFG_CYCLE_COUNT, CFG_KEEP_SUPER};
        val_list = '{own, slots, cycles, keep};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= idx_list[i];
            cfg_wdata <= val_list[i];
            @(posedge aclk);
            sb.write_reg(idx_list[i], val_list[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly ticks; packets lean toward sources that win over the current one
    function automatic in_word_t random_event();
        in_word_t w;
        int unsigned pick;
        int unsigned cyc_lim;
        w = in_word_t'({$urandom, $urandom});
        w.req_type = ($urandom_range(0, 3) == 0) ? REQ_PKT : REQ_TICK;
        if (w.req_type == REQ_PKT) begin
            w.pkt_ok = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                w.pkt_time_src = (sb.src_id == 0) ? 16'd0
                               : 16'($urandom_range(0, sb.src_id - 1));
            else if (pick < 7)
                w.pkt_time_src = sb.own_id;
            cyc_lim = (sb.cycle_count > 256) ? 256 : sb.cycle_count;
            if ($urandom_range(0, 4) != 0)
                w.pkt_cycle = 8'($urandom_range(0, cyc_lim));
            pick = $urandom_range(0, 5);
            if (pick == 1)
                w.pkt_sender = 16'($urandom_range((sb.slot_count > 1) ? sb.slot_count - 2 : 0,
                                                  sb.slot_count));
            else if (pick > 1)
                w.pkt_sender = 16'($urandom_range(0, sb.slot_count));
        end
        return w;
    endfunction

    task automatic run_random_events(int count);
        for (int i = 0; i < count; i++)
            offer_event(random_event(), idle_gap());
        s_valid <= 1'b0;
    endtask

    function automatic in_word_t pkt_word(logic ok, logic [15:0] src, logic [7:0] cyc,
                                          logic [15:0] sender);
        in_word_t w;
        w.req_type = REQ_PKT;
        w.pkt_ok = ok;
        w.pkt_time_src = src;
        w.pkt_cycle = cyc;
        w.pkt_sender = sender;
        return w;
    endfunction

    initial begin : stimulus
        in_word_t tick_w;
        in_word_t directed [$];
        tick_w = '0;
        tick_w.req_type = REQ_TICK;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: source is own ID 0, nothing can win
        offer_event(tick_w, 0);
        offer_event(pkt_word(1'b1, 16'h0000, 8'hFF, 16'hFFFF), 0);
        s_valid <= 1'b0;
        settle();

        // Tiny frame: slot count 2, cycle count 2, own slot 1, keep_supercycles 1
        apply_settings(16'd1, 16'd2, 16'd2, 16'd1);
        repeat (4) directed.push_back(tick_w);
        directed.push_back(pkt_word(1'b0, 16'h0000, 8'h00, 16'h0000));
        directed.push_back(pkt_word(1'b1, 16'h0001, 8'h00, 16'h0000));
        directed.push_back(pkt_word(1'b1, 16'hFFFF, 8'h01, 16'h0001));
        // resync at all-ones slot and cycle: both wrap, supercycle ages source
        directed.push_back(pkt_word(1'b1, 16'h0000, 8'hFF, 16'hFFFF));
        // enough ticks for the foreign source to go stale and drop back
        repeat (8) directed.push_back(tick_w);
        directed.push_back(pkt_word(1'b1, 16'h0000, 8'h01, 16'h0000));
        directed.push_back(pkt_word(1'b1, 16'h0000, 8'h00, 16'h0001));
        foreach (directed[i])
            offer_event(directed[i], (i % 3 == 0) ? idle_gap() : 0);
        s_valid <= 1'b0;
        run_random_events(200);
        settle();

        apply_settings(16'd5, 16'd8, 16'd3, 16'd0);
        run_random_events(300);
        settle();

        // Zero counts behave as one
        apply_settings(16'd0, 16'd0, 16'd0, 16'd255);
        run_random_events(150);
        settle();

        // All-ones writes but keep 0: widest counts, cycle count clamps to 256
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        run_random_events(200);
        settle();

        apply_settings(16'd3, 16'd4096, 16'd256, 16'd255);
        run_random_events(150);
        settle();

        // One slot, one cycle: every tick wraps the supercycle
        apply_settings(16'd1, 16'd1, 16'd1, 16'd2);
        run_random_events(250);
        settle();

        // Sink holds off for a long stretch while words keep coming
        apply_settings(16'd7, 16'd16, 16'd4, 16'd3);
        hold_off_req = 1'b1;
        run_random_events(400);
        settle();

        if (sb.pending() != 0) begin
            $error("%0d result words never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tss_pkg.sv
sv/tss_core.sv
sv/tdma_slot_sync.sv
tb/tb.sv
